FILE: hw/rtl/scma_pkg.sv
// scma_pkg: shared constants and controller/datapath handshake types
// for the segmented centred moving average block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package scma_pkg;

   // fixed field widths
   localparam int SAMPLE_W = 32;
   localparam int RADIUS_W = 4;

   // window radius after reset
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(2);

   // commands from controller to datapath
   typedef struct packed {
      logic load;        // capture the accepted item
      logic drop_old;    // drop oldest value ahead of an insert, if the window is full
      logic insert;      // write sample into the ring and the running sum
      logic flush_drop;  // one flush step: conditional drop, count down
      logic div_start;   // start the serial divider on the current sum
      logic out_load;    // capture the quotient into the result register
      logic clear;       // clear the history at segment end
   } scma_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic emit;        // the last insert produced a centre
      logic ends;        // the current item ends its segment
      logic flush_zero;  // no flush centres left
      logic div_done;    // divider has finished
   } scma_status_type;

endpackage : scma_pkg

`default_nettype wire

FILE: hw/rtl/scma_ifs.sv
// scma_ifs: valid/ready channel interfaces for samples, results and
// the radius register; depends on scma_pkg
`timescale 1ns / 1ps
`default_nettype none

// sample channel
interface scma_req_if import scma_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       ends_segment;

   modport source (output valid, output sample, output ends_segment, input ready);
   modport sink   (input valid, input sample, input ends_segment, output ready);
endinterface : scma_req_if

// result channel
interface scma_rsp_if import scma_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] smoothed;
   logic                       last_of_run;

   modport source (output valid, output smoothed, output last_of_run, input ready);
   modport sink   (input valid, input smoothed, input last_of_run, output ready);
endinterface : scma_rsp_if

// radius register write channel
interface scma_csr_if import scma_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [RADIUS_W-1:0] window_radius;

   modport source (output valid, output window_radius, input ready);
   modport sink   (input valid, input window_radius, output ready);
endinterface : scma_csr_if

`default_nettype wire

FILE: hw/rtl/scma_dp.sv
// scma_dp: datapath with sample ring, running sum, counters, radius
// register and bit-serial divider; depends on scma_pkg
`timescale 1ns / 1ps
`default_nettype none

module scma_dp import scma_pkg::*; #(
   parameter int MAX_RADIUS = 15
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire scma_cmd_type               cmd,
   output scma_status_type                 status,
   input  wire logic signed [SAMPLE_W-1:0] sample,
   input  wire logic                       ends_segment,
   input  wire logic                       csr_write,
   input  wire logic [RADIUS_W-1:0]        csr_radius,
   output logic signed [SAMPLE_W-1:0]      smoothed
);

   localparam int RING   = 2 * MAX_RADIUS + 1;
   localparam int PTR_W  = $clog2(RING);
   localparam int CNT_W  = $clog2(RING + 1);
   localparam int SUM_W  = SAMPLE_W + CNT_W;
   localparam int CMP_W  = ((CNT_W > RADIUS_W) ? CNT_W : RADIUS_W) + 1;
   localparam int DCNT_W = $clog2(SUM_W + 1);

   // ring memory and registered read at the tail
   logic [SAMPLE_W-1:0] ring_mem [RING];
   logic [SAMPLE_W-1:0] rd_ff;

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       ends_ff;
   logic [RADIUS_W-1:0]        radius_ff;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]           viw_ff, viw_in;
   logic [PTR_W-1:0]           head_ff, head_in, tail_ff, tail_in;
   logic [RADIUS_W-1:0]        fill_ff, fill_in;
   logic [RADIUS_W-1:0]        flush_ff, flush_in;
   logic                       emit_ff, emit_in;

   // divider state
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dvs_ff;
   logic              neg_ff;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;

   logic [CMP_W-1:0]    r_cmp, viw_cmp;
   logic [RADIUS_W-1:0] r_eff;
   logic [RADIUS_W-1:0] fill_next;
   logic                drop_now;
   logic [SUM_W-1:0]    sum_abs;
   logic [CNT_W+1:0]    trial;
   logic                trial_ok;
   logic [SUM_W-1:0]    quo_signed;
   logic [PTR_W-1:0]    head_inc, tail_inc;

   // effective radius, clipped to the ring
   always_comb begin
      if (CMP_W'(radius_ff) > CMP_W'(MAX_RADIUS)) begin
         r_cmp = CMP_W'(MAX_RADIUS);
      end else begin
         r_cmp = CMP_W'(radius_ff);
      end
      r_eff   = RADIUS_W'(r_cmp);
      viw_cmp = CMP_W'(viw_ff);
   end

   // ring pointer wrap
   always_comb begin
      head_inc = (head_ff == PTR_W'(RING - 1)) ? '0 : head_ff + PTR_W'(1);
      tail_inc = (tail_ff == PTR_W'(RING - 1)) ? '0 : tail_ff + PTR_W'(1);
   end

   // fill count after an insert, saturating at the radius
   assign fill_next = (fill_ff < r_eff) ? fill_ff + RADIUS_W'(1) : fill_ff;

   // drop decision for an insert or a flush step
   always_comb begin
      drop_now = 1'b0;
      if (cmd.drop_old) begin
         drop_now = (viw_cmp > r_cmp + r_cmp) || (viw_cmp >= CMP_W'(RING));
      end else if (cmd.flush_drop) begin
         drop_now = viw_cmp > r_cmp + CMP_W'(flush_ff);
      end
   end

   // window state update
   always_comb begin
      sum_in   = sum_ff;
      viw_in   = viw_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      fill_in  = fill_ff;
      flush_in = flush_ff;
      emit_in  = emit_ff;
      if (cmd.clear) begin
         sum_in  = '0;
         viw_in  = '0;
         head_in = '0;
         tail_in = '0;
         fill_in = '0;
      end else if (drop_now && viw_ff != '0) begin
         sum_in  = sum_ff - SUM_W'(signed'(rd_ff));
         viw_in  = viw_ff - CNT_W'(1);
         tail_in = tail_inc;
      end else if (cmd.insert) begin
         sum_in   = sum_ff + SUM_W'(sample_ff);
         viw_in   = viw_ff + CNT_W'(1);
         head_in  = head_inc;
         emit_in  = fill_ff >= r_eff;
         fill_in  = fill_next;
         flush_in = (fill_next < r_eff) ? fill_next : r_eff;
      end
      if (cmd.flush_drop) begin
         flush_in = flush_ff - RADIUS_W'(1);
      end
   end

   // magnitude of the sum for the divider
   assign sum_abs = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   // one restoring division step per cycle
   always_comb begin
      trial    = {1'b0, rem_ff, quo_ff[SUM_W-1]} - {2'b00, dvs_ff};
      trial_ok = !trial[CNT_W+1];
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dcnt_in  = dcnt_ff;
      if (cmd.div_start) begin
         quo_in  = sum_abs;
         rem_in  = '0;
         dcnt_in = DCNT_W'(SUM_W);
      end else if (dcnt_ff != '0) begin
         quo_in  = {quo_ff[SUM_W-2:0], trial_ok};
         rem_in  = trial_ok ? trial[CNT_W-1:0] : {rem_ff[CNT_W-2:0], quo_ff[SUM_W-1]};
         dcnt_in = dcnt_ff - DCNT_W'(1);
      end
   end

   assign quo_signed = neg_ff ? (~quo_ff + SUM_W'(1)) : quo_ff;

   // control and window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         sum_ff    <= '0;
         viw_ff    <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         fill_ff   <= '0;
         flush_ff  <= '0;
         emit_ff   <= 1'b0;
         dcnt_ff   <= '0;
      end else begin
         if (csr_write) begin
            radius_ff <= csr_radius;
         end
         sum_ff   <= sum_in;
         viw_ff   <= viw_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         fill_ff  <= fill_in;
         flush_ff <= flush_in;
         emit_ff  <= emit_in;
         dcnt_ff  <= dcnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= sample;
         ends_ff   <= ends_segment;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (cmd.div_start) begin
         dvs_ff <= viw_ff;
         neg_ff <= sum_ff[SUM_W-1];
      end
      if (cmd.out_load) begin
         smoothed <= (dvs_ff == '0) ? '0 : signed'(quo_signed[SAMPLE_W-1:0]);
      end
   end

   // ring memory: write at the head, registered read at the tail
   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         ring_mem[head_ff] <= sample_ff;
      end
      rd_ff <= ring_mem[tail_ff];
   end

   // status to the controller
   always_comb begin
      status.emit       = emit_ff;
      status.ends       = ends_ff;
      status.flush_zero = flush_ff == '0;
      status.div_done   = dcnt_ff == '0;
   end

endmodule : scma_dp

`default_nettype wire

FILE: hw/rtl/scma_ctrl.sv
// scma_ctrl: sequencing state machine for item intake, flush and result
// hand-off; depends on scma_pkg
`timescale 1ns / 1ps
`default_nettype none

module scma_ctrl import scma_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output logic                 rsp_last,
   output scma_cmd_type         cmd,
   input  wire scma_status_type status
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DROP   = 3'd1;
   localparam logic [2:0] ST_ADD    = 3'd2;
   localparam logic [2:0] ST_DECIDE = 3'd3;
   localparam logic [2:0] ST_FDROP  = 3'd4;
   localparam logic [2:0] ST_FSTART = 3'd5;
   localparam logic [2:0] ST_DIV    = 3'd6;
   localparam logic [2:0] ST_OUT    = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       last_ff, last_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      last_in   = last_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // no intake while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = ST_DROP;
            end
         end
         ST_DROP: begin
            cmd.drop_old = 1'b1;
            state_in     = ST_ADD;
         end
         ST_ADD: begin
            cmd.insert = 1'b1;
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            priority if (status.emit) begin
               cmd.div_start = 1'b1;
               last_in       = !status.ends || status.flush_zero;
               state_in      = ST_DIV;
            end else if (status.ends) begin
               state_in = ST_FDROP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FDROP: begin
            cmd.flush_drop = 1'b1;
            state_in       = ST_FSTART;
         end
         ST_FSTART: begin
            cmd.div_start = 1'b1;
            last_in       = status.flush_zero;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.out_load = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (last_ff) begin
                  cmd.clear = status.ends;
                  state_in  = ST_IDLE;
               end else begin
                  state_in = ST_FDROP;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_last = last_ff;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

endmodule : scma_ctrl

`default_nettype wire

FILE: hw/rtl/segmented_centered_moving_average.sv
// segmented_centered_moving_average: top level joining controller and
// datapath; depends on scma_pkg, scma_ifs, scma_ctrl and scma_dp
`timescale 1ns / 1ps
`default_nettype none

// Centred moving average of radius R (window_radius, clipped to MAX_RADIUS)
// over segmented streams of signed 32-bit samples. Each accepted item enters
// a ring of 2*MAX_RADIUS+1 entries and a running sum; once R samples of the
// segment precede it, one average for the sample R places back is returned.
// An item flagged ends_segment also returns the remaining centres, then the
// history clears; last_of_run marks the final result of each item. Items are
// taken one at a time: a new item is accepted only once every result of the
// last one has been taken. An item passes through intake, a conditional drop
// of the oldest value, the insert and a decision; each centre and each flush
// result comes from the bit-serial divider, which resolves one quotient bit
// per cycle over the SUM_W bits of the sum (32 plus the count width), and is
// held until the result side takes it. The radius register is ready whenever
// reset is low and must only be written while the block is idle.
module segmented_centered_moving_average import scma_pkg::*; #(
   parameter int MAX_RADIUS = 15
) (
   input wire logic  clock,
   input wire logic  reset,
   scma_req_if.sink  req_chan,
   scma_rsp_if.source rsp_chan,
   scma_csr_if.sink  csr_chan
);

   scma_cmd_type    cmd;
   scma_status_type status;

   // register writes are taken whenever reset is low
   assign csr_chan.ready = !reset;

   // sequencing
   scma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_last  (rsp_chan.last_of_run),
      .cmd       (cmd),
      .status    (status)
   );

   // window arithmetic and division
   scma_dp #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .sample       (req_chan.sample),
      .ends_segment (req_chan.ends_segment),
      .csr_write    (csr_chan.valid),
      .csr_radius   (csr_chan.window_radius),
      .smoothed     (rsp_chan.smoothed)
   );

endmodule : segmented_centered_moving_average

`default_nettype wire

FILE: bench/tb_top.sv
// tb_top: self-checking bench for segmented_centered_moving_average, with an
// in-bench window average predictor and result scoreboard
// depends on scma_pkg, scma_ifs and the block's rtl
`timescale 1ns / 1ps

module tb_top import scma_pkg::*; ();

   localparam int MAX_RADIUS   = 15;
   localparam int RING_DEPTH   = 2 * MAX_RADIUS + 1;
   localparam int SUM_W        = SAMPLE_W + 5;
   localparam int CLK_HALF     = 6;
   localparam int RESET_CYCLES = 11;
   localparam int SETTLE       = 16;
   localparam int TAIL_CYCLES  = 100;
   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 62;
   localparam int REPORT_MAX   = 10;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] smoothed;
      logic                       last_of_run;
   } average_type;

   // predicts the averages of each item and holds them until they come back
   class window_average_model_type;
      logic signed [SAMPLE_W-1:0] history [RING_DEPTH];
      logic signed [SUM_W-1:0]    running_sum;
      logic [4:0]                 held, head, tail, seg_fill;
      logic [RADIUS_W-1:0]        radius;
      average_type                expected_averages[$];
      int                         errors;

      function new();
         clear_history();
         radius = RADIUS_RESET;
         errors = 0;
      endfunction

      function void clear_history();
         for (int i = 0; i < RING_DEPTH; i++)
            history[i] = '0;
         running_sum = '0;
         held = '0;
         head = '0;
         tail = '0;
         seg_fill = '0;
      endfunction

      function void set_radius(input logic [RADIUS_W-1:0] value);
         radius = value;
      endfunction

      function void drop_oldest();
         if (held != 0) begin
            running_sum = running_sum - history[tail];
            tail = (tail == RING_DEPTH - 1) ? 5'd0 : tail + 5'd1;
            held = held - 5'd1;
         end
      endfunction

      function logic signed [SAMPLE_W-1:0] window_mean();
         logic signed [SUM_W-1:0] divisor;
         logic signed [SUM_W-1:0] quotient;
         if (held == 0)
            return '0;
         divisor = SUM_W'(held);
         quotient = running_sum / divisor;
         return quotient[SAMPLE_W-1:0];
      endfunction

      // one accepted sample: insert, maybe emit a centre, flush at segment end
      function void note_sample(input logic signed [SAMPLE_W-1:0] sample, input logic ends);
         int                         r;
         int                         flush;
         logic signed [SAMPLE_W-1:0] means[$];
         average_type                item;
         r = (radius > MAX_RADIUS) ? MAX_RADIUS : int'(radius);
         if (held > 2 * r || held >= RING_DEPTH)
            drop_oldest();
         history[head] = sample;
         head = (head == RING_DEPTH - 1) ? 5'd0 : head + 5'd1;
         running_sum = running_sum + sample;
         held = held + 5'd1;
         if (seg_fill >= r)
            means.push_back(window_mean());
         if (seg_fill < r)
            seg_fill = seg_fill + 5'd1;
         if (ends) begin
            flush = (seg_fill < r) ? int'(seg_fill) : r;
            for (int i = 1; i <= flush; i++) begin
               // shrink the window towards the segment end before each centre
               if (held > r + 1 + (flush - i))
                  drop_oldest();
               means.push_back(window_mean());
            end
            clear_history();
         end
         foreach (means[i]) begin
            item.smoothed = means[i];
            item.last_of_run = (i == means.size() - 1);
            expected_averages.push_back(item);
         end
      endfunction

      function void note_error(input string text);
         errors++;
         if (errors <= REPORT_MAX)
            $display("%s", text);
      endfunction

      function void check_smoothed(input logic signed [SAMPLE_W-1:0] smoothed,
                                   input logic last_of_run);
         average_type want;
         if (expected_averages.size() == 0) begin
            note_error($sformatf("unexpected result: smoothed %0d last_of_run %0b",
                                 smoothed, last_of_run));
            return;
         end
         want = expected_averages.pop_front();
         if (smoothed !== want.smoothed || last_of_run !== want.last_of_run)
            note_error($sformatf("mismatch: expected smoothed %0d last_of_run %0b, got %0d %0b",
                                 want.smoothed, want.last_of_run, smoothed, last_of_run));
      endfunction

      function int pending();
         return expected_averages.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   int                       sender_idle_pct;
   int                       receiver_stall_pct;
   int                       quiet_cycles;
   window_average_model_type averages;

   scma_req_if req_if ();
   scma_rsp_if rsp_if ();
   scma_csr_if csr_if ();

   segmented_centered_moving_average #(
      .MAX_RADIUS(MAX_RADIUS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source),
      .csr_chan (csr_if.sink)
   );

   // clock
   always #CLK_HALF clock = ~clock;

   // result side back-pressure
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // compare each returned average with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         averages.check_smoothed(rsp_if.smoothed, rsp_if.last_of_run);
   end

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // offer one item, idling at random first, and note it once taken
   task automatic send_item(input logic signed [SAMPLE_W-1:0] sample, input logic ends);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.sample <= sample;
      req_if.ends_segment <= ends;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      averages.note_sample(sample, ends);
   endtask

   // stop offering items and wait for every predicted average to return
   task automatic wait_for_drain(input int settle);
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (averages.pending() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_radius(input logic [RADIUS_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.window_radius <= value;
      @(posedge clock);
      while (!csr_if.ready)
         @(posedge clock);
      averages.set_radius(value);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return $signed(32'($urandom_range(16))) - 32'sd8;
         default: return $signed($urandom);
      endcase
   endfunction

   // mostly short segments around the window size, a few that wrap the ring
   function automatic int pick_length(input int r);
      if ($urandom_range(9) == 0)
         return $urandom_range(70, 32);
      return $urandom_range(2 * r + 6, 1);
   endfunction

   function automatic void set_idling(input idle_mode_type mode);
      sender_idle_pct = (mode == IDLE_SENDER) ? 65 : (mode == IDLE_BOTH) ? 8 : 0;
      receiver_stall_pct = (mode == IDLE_RECEIVER) ? 65 : (mode == IDLE_BOTH) ? 8 : 0;
   endfunction

   initial begin : stimulus
      logic [RADIUS_W-1:0]        radius_plan [PHASES];
      logic signed [SAMPLE_W-1:0] value;
      logic                       ends;
      int                         seg_left;

      clock = 1'b0;
      reset = 1'b1;
      quiet_cycles = 0;
      req_if.valid = 1'b0;
      req_if.sample = '0;
      req_if.ends_segment = 1'b0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.window_radius = '0;
      averages = new();
      set_idling(IDLE_NONE);

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // reset radius: saturated samples, a lone sample segment, small values
      send_item(32'sh7fff_ffff, 1'b0);
      send_item(32'sh7fff_ffff, 1'b0);
      send_item(32'sh7fff_ffff, 1'b0);
      send_item(32'sh8000_0000, 1'b0);
      send_item(32'sh8000_0000, 1'b1);
      send_item(-32'sd1, 1'b1);
      send_item(32'sd0, 1'b0);
      send_item(32'sd1, 1'b1);

      // widest window with alternating extremes, full flush at the end
      wait_for_drain(SETTLE);
      write_radius(RADIUS_W'(MAX_RADIUS));
      for (int i = 0; i < 17; i++)
         send_item(i[0] ? 32'sh8000_0000 : 32'sh7fff_ffff, i == 16);

      radius_plan[0] = 4'd0;
      radius_plan[1] = 4'd15;
      radius_plan[2] = 4'd1;
      radius_plan[3] = RADIUS_W'($urandom_range(14, 2));
      radius_plan[4] = 4'd15;
      radius_plan[5] = 4'd3;
      radius_plan[6] = 4'd0;
      radius_plan[7] = RADIUS_W'($urandom_range(15));

      // random phases; a segment left open crosses the radius change
      seg_left = 0;
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_drain(SETTLE);
         write_radius(radius_plan[phase]);
         set_idling(idle_mode_type'(phase % 4));
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (phase == 5 && k == PHASE_ITEMS / 2)
               wait_for_drain(0);
            if (seg_left == 0)
               seg_left = pick_length(int'(radius_plan[phase]));
            seg_left--;
            ends = (seg_left == 0);
            // occasional broken segment: early end or a missing end flag
            if ($urandom_range(99) < 8)
               ends = ~ends;
            if (ends)
               seg_left = 0;
            value = pick_sample();
            send_item(value, ends);
         end
      end

      wait_for_drain(TAIL_CYCLES);
      if (averages.pending() != 0)
         averages.note_error($sformatf("%0d averages never returned", averages.pending()));
      if (averages.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule : tb_top

FILE: filelist.f
hw/rtl/scma_pkg.sv
hw/rtl/scma_ifs.sv
hw/rtl/scma_dp.sv
hw/rtl/scma_ctrl.sv
hw/rtl/segmented_centered_moving_average.sv
bench/tb_top.sv
